>>> rtl/csdo_pkg.sv
// csdo_pkg: shared types and constants of the cursor shape decode and overlay block.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package csdo_pkg;

   // Field and register widths
   localparam int OP_W       = 2;
   localparam int TBL_W      = 4;
   localparam int PIX_W      = 8;
   localparam int COORD_W    = 12;
   localparam int SCR_W      = 13;
   localparam int HOT_W      = 6;
   localparam int DIM_W      = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;
   // Signed geometry width: holds hotspot-shifted edges and the viewport size
   localparam int GW         = 15;

   localparam int REMAP_ENTRIES = 16;

   // Opcodes
   localparam logic [OP_W-1:0] OP_START = 2'd0;
   localparam logic [OP_W-1:0] OP_TABLE = 2'd1;
   localparam logic [OP_W-1:0] OP_SHAPE = 2'd2;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOT_X         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HOT_Y         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SHAPE_WIDTH   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SHAPE_HEIGHT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_REMAP_ENABLE  = 3'd6;

   // Register reset values
   localparam logic [SCR_W-1:0] RST_SCREEN_WIDTH  = 13'd640;
   localparam logic [SCR_W-1:0] RST_SCREEN_HEIGHT = 13'd400;
   localparam logic [HOT_W-1:0] RST_HOT           = 6'd0;
   localparam logic [DIM_W-1:0] RST_SHAPE_DIM     = 7'd64;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;     // item taken this cycle
      logic geo_edge;   // compute shape edges on screen
      logic geo_clip;   // clip, test position, form row/column offsets
      logic rd_issue;   // read image at row * pitch + column
      logic capture;    // latch composited pixel
      logic run_step;   // store one transparent pixel of a zero run
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_query;   // request is a pixel query
      logic run_go;     // request starts a nonempty zero run
      logic run_last;   // last pixel of the current run
   } ctrl_status_type;

endpackage

>>> rtl/csdo_ram.sv
// csdo_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module csdo_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/csdo_ctrl.sv
// csdo_ctrl: sequencer of the cursor block; steps queries and zero runs.
// Depends on csdo_pkg for the command and status structs.
`timescale 1ns / 1ps

module csdo_ctrl import csdo_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd,
   output logic            busy,
   output logic            rsp_valid
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_Q_EDGE,
      ST_Q_CLIP,
      ST_Q_ADDR,
      ST_Q_DATA,
      ST_RUN,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;
   logic      rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (status.is_query) begin
                  state_in = ST_Q_EDGE;
               end else if (status.run_go) begin
                  state_in = ST_RUN;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_Q_EDGE: state_in = ST_Q_CLIP;
         ST_Q_CLIP: state_in = ST_Q_ADDR;
         ST_Q_ADDR: state_in = ST_Q_DATA;
         ST_Q_DATA: state_in = ST_RESP;
         ST_RUN: begin
            if (status.run_last) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= (state_in != ST_IDLE);
         rsp_valid_ff <= (state_in == ST_RESP);
      end
   end

   always_comb begin
      cmd          = '0;
      cmd.accept   = start && !busy_ff;
      cmd.geo_edge = (state_ff == ST_Q_EDGE);
      cmd.geo_clip = (state_ff == ST_Q_CLIP);
      cmd.rd_issue = (state_ff == ST_Q_ADDR);
      cmd.capture  = (state_ff == ST_Q_DATA);
      cmd.run_step = (state_ff == ST_RUN);
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   a_done_after_rsp: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> $past(rsp_valid))
      else $error("busy dropped without a result");
`endif

endmodule

>>> rtl/csdo_dp.sv
// csdo_dp: datapath of the cursor block: registers, remap table, shape decode,
// clip geometry and image RAM. Depends on csdo_pkg and csdo_ram.
`timescale 1ns / 1ps

module csdo_dp import csdo_pkg::*; #(
   parameter int MAX_CURSOR_WIDTH  = 64,
   parameter int MAX_CURSOR_HEIGHT = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctrl_cmd_type          cmd,
   output ctrl_status_type       status,
   input  logic [OP_W-1:0]       req_opcode,
   input  logic [TBL_W-1:0]      req_table_index,
   input  logic [PIX_W-1:0]      req_data_byte,
   input  logic [COORD_W-1:0]    req_cursor_x,
   input  logic [COORD_W-1:0]    req_cursor_y,
   input  logic [COORD_W-1:0]    req_screen_x,
   input  logic [COORD_W-1:0]    req_screen_y,
   input  logic [PIX_W-1:0]      req_background,
   output logic [PIX_W-1:0]      rsp_pixel,
   output logic                  rsp_cursor_hit,
   output logic                  rsp_shape_complete,
   output logic                  rsp_run_overflow,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int DEPTH = MAX_CURSOR_WIDTH * MAX_CURSOR_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > PIX_W) ? CNT_W : PIX_W;
   localparam logic [DIM_W+1:0] MAXW_V = (DIM_W+2)'(MAX_CURSOR_WIDTH);
   localparam logic [DIM_W+1:0] MAXH_V = (DIM_W+2)'(MAX_CURSOR_HEIGHT);
   localparam logic signed [GW-1:0] ZERO_S = '0;
   localparam logic signed [GW-1:0] ONE_S  = GW'(1);

   // Configuration registers
   logic [SCR_W-1:0] scr_w_ff, scr_h_ff;
   logic [HOT_W-1:0] hot_x_ff, hot_y_ff;
   logic [DIM_W-1:0] shp_w_ff, shp_h_ff;
   logic             remap_en_ff;

   // Remap table, no reset
   logic [PIX_W-1:0] remap_ff [REMAP_ENTRIES];

   // Load state
   logic [CNT_W-1:0] ptr_ff, pl_ff;
   logic             expect_ff;
   logic [PIX_W-1:0] run_ff;
   logic             ovf_ff;

   // Query operands and geometry
   logic [COORD_W-1:0]     cx_ff, cy_ff, sx_ff, sy_ff;
   logic [PIX_W-1:0]       bg_ff;
   logic signed [GW-1:0]   xs_ff, ys_ff, xe_ff, ye_ff;
   logic signed [GW-1:0]   xs_in, ys_in;
   logic                   in_ff;
   logic [DIM_W-1:0]       row_ff, col_ff;
   logic [PIX_W-1:0]       pix_ff;
   logic                   hit_ff;

   logic                   dims_ok;
   logic [2*DIM_W-1:0]     prod;
   logic                   pl_zero;
   logic                   shape_live;
   logic                   pix_write;
   logic                   run_begin;
   logic                   run_clip;
   logic [PIX_W-1:0]       run_len;
   logic [PIX_W-1:0]       remap_val;
   logic signed [GW-1:0]   sw_s, sh_s, sw_m1, sh_m1, sx_s, sy_s;
   logic signed [GW-1:0]   x0, y0, x1, y1, row_s, col_s;
   logic                   early_rej, in_rect;
   logic [2*DIM_W-1:0]     idx;
   logic                   ram_we;
   logic [PIX_W-1:0]       ram_wdata;
   logic [PIX_W-1:0]       ram_rdata;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scr_w_ff    <= RST_SCREEN_WIDTH;
         scr_h_ff    <= RST_SCREEN_HEIGHT;
         hot_x_ff    <= RST_HOT;
         hot_y_ff    <= RST_HOT;
         shp_w_ff    <= RST_SHAPE_DIM;
         shp_h_ff    <= RST_SHAPE_DIM;
         remap_en_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  scr_w_ff    <= csr_data[SCR_W-1:0];
            CSR_SCREEN_HEIGHT: scr_h_ff    <= csr_data[SCR_W-1:0];
            CSR_HOT_X:         hot_x_ff    <= csr_data[HOT_W-1:0];
            CSR_HOT_Y:         hot_y_ff    <= csr_data[HOT_W-1:0];
            CSR_SHAPE_WIDTH:   shp_w_ff    <= csr_data[DIM_W-1:0];
            CSR_SHAPE_HEIGHT:  shp_h_ff    <= csr_data[DIM_W-1:0];
            CSR_REMAP_ENABLE:  remap_en_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && req_opcode == OP_TABLE) begin
         remap_ff[req_table_index] <= req_data_byte;
      end
   end

   // Shape decode
   assign dims_ok = (shp_w_ff != '0) && ({2'b00, shp_w_ff} <= MAXW_V) &&
                    (shp_h_ff != '0) && ({2'b00, shp_h_ff} <= MAXH_V);
   assign prod       = {{DIM_W{1'b0}}, shp_w_ff} * {{DIM_W{1'b0}}, shp_h_ff};
   assign pl_zero    = (pl_ff == '0);
   assign shape_live = cmd.accept && (req_opcode == OP_SHAPE) && !pl_zero;
   assign pix_write  = shape_live && !expect_ff && (req_data_byte != '0);
   assign run_begin  = shape_live && expect_ff;
   assign run_clip   = CMP_W'(req_data_byte) > CMP_W'(pl_ff);
   assign run_len    = run_clip ? PIX_W'(pl_ff) : req_data_byte;

   // With remap enabled, bytes below the table size map through it; larger ones pass as is
   assign remap_val = (remap_en_ff && req_data_byte[PIX_W-1:TBL_W] == '0) ?
                      remap_ff[req_data_byte[TBL_W-1:0]] : req_data_byte;

   assign status.is_query = (req_opcode == OP_QUERY);
   assign status.run_go   = (req_opcode == OP_SHAPE) && !pl_zero && expect_ff &&
                            (req_data_byte != '0);
   assign status.run_last = (run_ff == PIX_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff    <= '0;
         pl_ff     <= '0;
         expect_ff <= 1'b0;
         run_ff    <= '0;
         ovf_ff    <= 1'b0;
      end else if (cmd.accept) begin
         ovf_ff <= run_begin && run_clip;
         unique case (req_opcode)
            OP_START: begin
               ptr_ff    <= '0;
               expect_ff <= 1'b0;
               pl_ff     <= dims_ok ? CNT_W'(prod) : '0;
            end
            OP_SHAPE: begin
               if (pix_write) begin
                  ptr_ff <= ptr_ff + CNT_W'(1);
                  pl_ff  <= pl_ff - CNT_W'(1);
               end
               if (run_begin) begin
                  expect_ff <= 1'b0;
                  run_ff    <= run_len;
               end else if (shape_live && req_data_byte == '0) begin
                  expect_ff <= 1'b1;
               end
            end
            OP_TABLE: ;
            OP_QUERY: ;
         endcase
      end else if (cmd.run_step) begin
         ptr_ff <= ptr_ff + CNT_W'(1);
         pl_ff  <= pl_ff - CNT_W'(1);
         run_ff <= run_ff - PIX_W'(1);
      end
   end

   // Query geometry, stage 1: shape edges on screen
   assign xs_in = GW'(cx_ff) - GW'(hot_x_ff);
   assign ys_in = GW'(cy_ff) - GW'(hot_y_ff);

   // Stage 2: clipped rectangle, early rejects, offsets into the shape
   assign sw_s  = GW'(scr_w_ff);
   assign sh_s  = GW'(scr_h_ff);
   assign sw_m1 = sw_s - ONE_S;
   assign sh_m1 = sh_s - ONE_S;
   assign sx_s  = GW'(sx_ff);
   assign sy_s  = GW'(sy_ff);
   assign x0    = (xs_ff < ZERO_S) ? ZERO_S : xs_ff;
   assign y0    = (ys_ff < ZERO_S) ? ZERO_S : ys_ff;
   assign x1    = (xe_ff < sw_m1) ? xe_ff : sw_m1;
   assign y1    = (ye_ff < sh_m1) ? ye_ff : sh_m1;
   assign early_rej = (xs_ff >= sw_s) || (ys_ff >= sh_s) ||
                      (xe_ff <= ZERO_S) || (ye_ff <= ZERO_S);
   // thin clipped extent (one row or one column) is not drawn
   assign in_rect = dims_ok && !early_rej && (x1 > x0) && (y1 > y0) &&
                    (sx_s >= x0) && (sx_s <= x1) && (sy_s >= y0) && (sy_s <= y1);
   assign row_s = sy_s - ys_ff;
   assign col_s = sx_s - xs_ff;

   // Stage 3: image address, pitch is the current shape width
   assign idx = {{DIM_W{1'b0}}, row_ff} * {{DIM_W{1'b0}}, shp_w_ff} +
                {{DIM_W{1'b0}}, col_ff};

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cx_ff  <= req_cursor_x;
         cy_ff  <= req_cursor_y;
         sx_ff  <= req_screen_x;
         sy_ff  <= req_screen_y;
         bg_ff  <= req_background;
         pix_ff <= '0;
         hit_ff <= 1'b0;
      end
      if (cmd.geo_edge) begin
         xs_ff <= xs_in;
         ys_ff <= ys_in;
         xe_ff <= xs_in + GW'(shp_w_ff) - ONE_S;
         ye_ff <= ys_in + GW'(shp_h_ff) - ONE_S;
      end
      if (cmd.geo_clip) begin
         in_ff  <= in_rect;
         row_ff <= DIM_W'(row_s);
         col_ff <= DIM_W'(col_s);
      end
      if (cmd.capture) begin
         hit_ff <= in_ff && (ram_rdata != '0);
         pix_ff <= (in_ff && ram_rdata != '0) ? ram_rdata : bg_ff;
      end
   end

   assign ram_we    = pix_write || cmd.run_step;
   assign ram_wdata = cmd.run_step ? '0 : remap_val;

   csdo_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_image (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ptr_ff[AW-1:0]),
      .wr_data (ram_wdata),
      .rd_en   (cmd.rd_issue),
      .rd_addr (AW'(idx)),
      .rd_data (ram_rdata)
   );

   assign rsp_pixel          = pix_ff;
   assign rsp_cursor_hit     = hit_ff;
   assign rsp_shape_complete = pl_zero;
   assign rsp_run_overflow   = ovf_ff;

`ifndef ASSERT_OFF
   a_run_has_room: assert property (@(posedge clock) disable iff (reset)
      cmd.run_step |-> !pl_zero)
      else $error("run pixel stored with no pixels left");

   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (ptr_ff < CNT_W'(DEPTH)))
      else $error("image write beyond depth");
`endif

endmodule

>>> rtl/cursor_shape_decode_and_overlay.sv
// cursor_shape_decode_and_overlay: top level of the hardware cursor block.
// Depends on csdo_pkg, csdo_ctrl, csdo_dp (which holds csdo_ram).
`timescale 1ns / 1ps

// Usage
//  Request: drive req_* and raise start; the item is taken at a clock edge
//  where start is high and busy is low. Opcodes: start shape load, remap
//  table write, shape byte, pixel query.
//  Result: exactly one per item, on rsp_* for a single cycle with rsp_valid
//  high. The receiver cannot stall; the result must be taken that cycle.
//  Config: csr_valid/csr_ready with csr_index and csr_data; csr_ready is
//  always high. Write only while busy is low.
//  Sequencing, from the accepting edge to the result cycle:
//   load start, table write, plain shape byte: result next cycle.
//   shape byte ending a zero run of n stored pixels: one image write per
//   cycle through the single RAM write port, then the result.
//   pixel query: edge, clip, address and RAM read stages, then the result.
//   Busy stays high until the result, so no new item is taken before it.
//  Reset: registers return to their defaults, no load in progress; the
//  image RAM and the remap table are not cleared (undefined until loaded).
module cursor_shape_decode_and_overlay import csdo_pkg::*; #(
   parameter int MAX_CURSOR_WIDTH  = 64,
   parameter int MAX_CURSOR_HEIGHT = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  logic [OP_W-1:0]       req_opcode,
   input  logic [TBL_W-1:0]      req_table_index,
   input  logic [PIX_W-1:0]      req_data_byte,
   input  logic [COORD_W-1:0]    req_cursor_x,
   input  logic [COORD_W-1:0]    req_cursor_y,
   input  logic [COORD_W-1:0]    req_screen_x,
   input  logic [COORD_W-1:0]    req_screen_y,
   input  logic [PIX_W-1:0]      req_background,
   // result channel
   output logic                  rsp_valid,
   output logic [PIX_W-1:0]      rsp_pixel,
   output logic                  rsp_cursor_hit,
   output logic                  rsp_shape_complete,
   output logic                  rsp_run_overflow,
   // register write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // sequencer: owns busy and the result strobe
   csdo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // datapath: registers, decode, geometry, image store
   csdo_dp #(
      .MAX_CURSOR_WIDTH  (MAX_CURSOR_WIDTH),
      .MAX_CURSOR_HEIGHT (MAX_CURSOR_HEIGHT)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_opcode         (req_opcode),
      .req_table_index    (req_table_index),
      .req_data_byte      (req_data_byte),
      .req_cursor_x       (req_cursor_x),
      .req_cursor_y       (req_cursor_y),
      .req_screen_x       (req_screen_x),
      .req_screen_y       (req_screen_y),
      .req_background     (req_background),
      .rsp_pixel          (rsp_pixel),
      .rsp_cursor_hit     (rsp_cursor_hit),
      .rsp_shape_complete (rsp_shape_complete),
      .rsp_run_overflow   (rsp_run_overflow),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

endmodule

>>> tb/testbench.sv
// testbench: self-checking bench for cursor_shape_decode_and_overlay.
// Drives shape loads, remap writes and pixel queries, predicts every result
// in a scoreboard class. Depends on csdo_pkg and the block's RTL only.
`timescale 1ns / 1ps

module testbench;
   import csdo_pkg::*;

   localparam int MAX_W         = 64;
   localparam int MAX_H         = 64;
   localparam int CLK_HALF      = 6;
   localparam int RESET_CYCLES  = 5;
   // longest legal quiet stretch is a 255-pixel run plus a long sender gap
   localparam int STALL_LIMIT   = 3000;
   // quiet cycles added after the last result when settling
   localparam int SETTLE_CYCLES = 8;
   localparam int NUM_PHASES    = 16;
   localparam int PHASE_ITEMS   = 120;
   localparam int PRINT_CAP     = 200;

   // one request item, field per port
   typedef struct packed {
      logic [OP_W-1:0]    opcode;
      logic [TBL_W-1:0]   table_index;
      logic [PIX_W-1:0]   data_byte;
      logic [COORD_W-1:0] cursor_x;
      logic [COORD_W-1:0] cursor_y;
      logic [COORD_W-1:0] screen_x;
      logic [COORD_W-1:0] screen_y;
      logic [PIX_W-1:0]   background;
   } cursor_item_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             hit;
      logic             complete;
      logic             overflow;
   } overlay_result_type;

   // Scoreboard: private copy of the registers, the image, the remap table and
   // the load state. Every accepted item yields exactly one expected result.
   class cursor_scoreboard;
      localparam int DEPTH = MAX_W * MAX_H;

      logic [SCR_W-1:0]   scr_w, scr_h;
      logic [HOT_W-1:0]   hot_x, hot_y;
      logic [DIM_W-1:0]   shp_w, shp_h;
      logic               remap_on;

      logic [PIX_W-1:0]   image [DEPTH];
      bit                 image_valid [DEPTH];
      logic [PIX_W-1:0]   remap [REMAP_ENTRIES];
      bit                 remap_valid [REMAP_ENTRIES];
      int unsigned        load_ptr;
      int unsigned        pix_left;
      bit                 run_next;

      overlay_result_type overlay_results [$];
      int                 mismatches;

      function new();
         scr_w = RST_SCREEN_WIDTH;
         scr_h = RST_SCREEN_HEIGHT;
         hot_x = RST_HOT;
         hot_y = RST_HOT;
         shp_w = RST_SHAPE_DIM;
         shp_h = RST_SHAPE_DIM;
         remap_on = 1'b0;
         foreach (image[i]) image[i] = '0;
         foreach (remap[i]) remap[i] = '0;
         load_ptr = 0;
         pix_left = 0;
         run_next = 0;
         mismatches = 0;
      endfunction

      function void write_reg(input logic [CSR_IDX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_SCREEN_WIDTH:  scr_w = data[SCR_W-1:0];
            CSR_SCREEN_HEIGHT: scr_h = data[SCR_W-1:0];
            CSR_HOT_X:         hot_x = data[HOT_W-1:0];
            CSR_HOT_Y:         hot_y = data[HOT_W-1:0];
            CSR_SHAPE_WIDTH:   shp_w = data[DIM_W-1:0];
            CSR_SHAPE_HEIGHT:  shp_h = data[DIM_W-1:0];
            CSR_REMAP_ENABLE:  remap_on = data[0];
            default: ;
         endcase
      endfunction

      function bit dims_ok();
         return shp_w >= 1 && shp_w <= MAX_W && shp_h >= 1 && shp_h <= MAX_H;
      endfunction

      // 1 when the clipped cursor covers the queried position; addr is the
      // image entry that the query reads (current shape width as pitch)
      function bit locate(input cursor_item_type it, output int addr);
         int sw, sh, xs, ys, xe, ye, x0, y0, x1, y1, sx, sy, cx, cy;
         addr = 0;
         if (!dims_ok()) return 0;
         sw = scr_w;
         sh = scr_h;
         cx = it.cursor_x;
         cy = it.cursor_y;
         sx = it.screen_x;
         sy = it.screen_y;
         xs = cx - int'(hot_x);
         ys = cy - int'(hot_y);
         xe = xs + int'(shp_w) - 1;
         ye = ys + int'(shp_h) - 1;
         // left/top edge past the viewport, or right/bottom edge at 0 or less
         if (xs >= sw || ys >= sh || xe <= 0 || ye <= 0) return 0;
         x0 = xs < 0 ? 0 : xs;
         y0 = ys < 0 ? 0 : ys;
         x1 = xe < sw - 1 ? xe : sw - 1;
         y1 = ye < sh - 1 ? ye : sh - 1;
         // one pixel wide or high after clipping: not drawn
         if (!(x1 > x0 && y1 > y0)) return 0;
         if (sx < x0 || sx > x1 || sy < y0 || sy > y1) return 0;
         addr = (sy - ys) * int'(shp_w) + (sx - xs);
         return addr < DEPTH;
      endfunction

      function void store_pixel(input logic [PIX_W-1:0] v);
         if (load_ptr < DEPTH) begin
            image[load_ptr] = v;
            image_valid[load_ptr] = 1'b1;
         end
         load_ptr++;
         pix_left--;
      endfunction

      // advance the load/overlay state by one item and queue its result
      function void decode_or_overlay(input cursor_item_type it);
         overlay_result_type r;
         int unsigned run;
         int addr;
         logic [PIX_W-1:0] v;
         r = '0;
         case (it.opcode)
            OP_START: begin
               load_ptr = 0;
               run_next = 0;
               pix_left = dims_ok() ? int'(shp_w) * int'(shp_h) : 0;
            end
            OP_TABLE: begin
               remap[it.table_index] = it.data_byte;
               remap_valid[it.table_index] = 1'b1;
            end
            OP_SHAPE: begin
               if (pix_left != 0) begin
                  if (run_next) begin
                     run = it.data_byte;
                     run_next = 0;
                     if (run > pix_left) begin
                        run = pix_left;
                        r.overflow = 1'b1;
                     end
                     repeat (run) store_pixel('0);
                  end else if (it.data_byte != 0) begin
                     v = it.data_byte;
                     if (remap_on && it.data_byte < REMAP_ENTRIES)
                        v = remap[it.data_byte[TBL_W-1:0]];
                     store_pixel(v);
                  end else begin
                     run_next = 1;
                  end
               end
            end
            default: begin
               if (locate(it, addr) && image[addr] != 0) begin
                  r.pixel = image[addr];
                  r.hit = 1'b1;
               end else begin
                  r.pixel = it.background;
               end
            end
         endcase
         r.complete = (pix_left == 0);
         overlay_results.push_back(r);
      endfunction

      task report_mismatch(input string msg);
         if (mismatches < PRINT_CAP) $display("mismatch at %0t: %s", $time, msg);
         mismatches++;
      endtask

      task compare_overlay(input overlay_result_type got);
         overlay_result_type want;
         if (overlay_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", got));
         end else begin
            want = overlay_results.pop_front();
            if (got.pixel !== want.pixel)
               report_mismatch($sformatf("pixel exp %h got %h", want.pixel, got.pixel));
            if (got.hit !== want.hit)
               report_mismatch($sformatf("cursor_hit exp %b got %b", want.hit, got.hit));
            if (got.complete !== want.complete)
               report_mismatch($sformatf("shape_complete exp %b got %b",
                                         want.complete, got.complete));
            if (got.overflow !== want.overflow)
               report_mismatch($sformatf("run_overflow exp %b got %b",
                                         want.overflow, got.overflow));
         end
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [OP_W-1:0]       req_opcode;
   logic [TBL_W-1:0]      req_table_index;
   logic [PIX_W-1:0]      req_data_byte;
   logic [COORD_W-1:0]    req_cursor_x;
   logic [COORD_W-1:0]    req_cursor_y;
   logic [COORD_W-1:0]    req_screen_x;
   logic [COORD_W-1:0]    req_screen_y;
   logic [PIX_W-1:0]      req_background;
   logic                  rsp_valid;
   logic [PIX_W-1:0]      rsp_pixel;
   logic                  rsp_cursor_hit;
   logic                  rsp_shape_complete;
   logic                  rsp_run_overflow;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   cursor_scoreboard sb = new();
   int burst_left = 0;   // items still to send back to back

   cursor_shape_decode_and_overlay #(
      .MAX_CURSOR_WIDTH  (MAX_W),
      .MAX_CURSOR_HEIGHT (MAX_H)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_table_index    (req_table_index),
      .req_data_byte      (req_data_byte),
      .req_cursor_x       (req_cursor_x),
      .req_cursor_y       (req_cursor_y),
      .req_screen_x       (req_screen_x),
      .req_screen_y       (req_screen_y),
      .req_background     (req_background),
      .rsp_valid          (rsp_valid),
      .rsp_pixel          (rsp_pixel),
      .rsp_cursor_hit     (rsp_cursor_hit),
      .rsp_shape_complete (rsp_shape_complete),
      .rsp_run_overflow   (rsp_run_overflow),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // Results cannot be held off: every strobe outside reset is checked.
   // Sampling in the active region at the edge sees pre-edge values.
   always @(posedge clock) begin
      if (!reset && rsp_valid !== 1'b0)
         sb.compare_overlay({rsp_pixel, rsp_cursor_hit, rsp_shape_complete,
                             rsp_run_overflow});
   end

   // Watchdog: any item, result or register write restarts the count.
   initial begin : watchdog
      int stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid === 1'b1 || (csr_valid && csr_ready))
            stalled = 0;
         else
            stalled++;
      end
      $display("testbench: FAIL");
      $finish;
   end

   function automatic int clamp12(input int v);
      return v < 0 ? 0 : (v > 4095 ? 4095 : v);
   endfunction

   // mostly back to back or short gaps, a few long ones, and some
   // stretches sent with no gap at all
   function automatic int pick_gap();
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         burst_left = $urandom_range(10, 50);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic int pick_screen();
      case ($urandom_range(0, 9))
         0: return 1;
         1: return 4096;
         2: return $urandom_range(2, 4);
         3, 4: return $urandom_range(1, 4096);
         default: return $urandom_range(40, 200);
      endcase
   endfunction

   function automatic int pick_hot();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 63;
         2, 3, 4, 5: return $urandom_range(0, 3);
         default: return $urandom_range(0, 63);
      endcase
   endfunction

   // zero and oversize shapes show up now and then
   function automatic int pick_dim();
      case ($urandom_range(0, 19))
         0: return 0;
         1: return $urandom_range(65, 127);
         2, 3: return 64;
         4, 5: return 1;
         default: return $urandom_range(2, 8);
      endcase
   endfunction

   // cursor position: near the origin, near the far viewport edge, or anywhere
   function automatic int pick_anchor(input int extent);
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 4095);
         1: return 4095;
         2, 3, 4, 5: return $urandom_range(0, 80);
         default: return clamp12(extent - 70 + int'($urandom_range(0, 140)));
      endcase
   endfunction

   function automatic cursor_item_type mk(input logic [OP_W-1:0] op, input int tidx,
                                          input int data, input int cx, input int cy,
                                          input int sx, input int sy, input int bg);
      cursor_item_type it;
      it.opcode      = op;
      it.table_index = tidx[TBL_W-1:0];
      it.data_byte   = data[PIX_W-1:0];
      it.cursor_x    = cx[COORD_W-1:0];
      it.cursor_y    = cy[COORD_W-1:0];
      it.screen_x    = sx[COORD_W-1:0];
      it.screen_y    = sy[COORD_W-1:0];
      it.background  = bg[PIX_W-1:0];
      return it;
   endfunction

   // Random item shaped by the predicted load state: during a load most
   // items are stream bytes (pixels, run markers, run lengths), the rest
   // queries, table writes and restarts that break the sequence.
   function automatic cursor_item_type make_item();
      cursor_item_type it;
      int r, w, h, cx, cy, xs, addr;
      it = mk(OP_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom);
      r = $urandom_range(0, 99);
      if (sb.pix_left != 0)
         it.opcode = r < 70 ? OP_SHAPE : r < 88 ? OP_QUERY : r < 95 ? OP_TABLE : OP_START;
      else
         it.opcode = r < 30 ? OP_START : r < 75 ? OP_QUERY : r < 88 ? OP_TABLE : OP_SHAPE;

      if (it.opcode == OP_SHAPE && sb.pix_left != 0) begin
         r = $urandom_range(0, 9);
         if (sb.run_next) begin
            case (r)
               0: it.data_byte = 8'hFF;
               1: it.data_byte = (sb.pix_left + 20 > 255) ? 8'hFF
                                 : PIX_W'(sb.pix_left + $urandom_range(1, 20));
               2: it.data_byte = (sb.pix_left > 255) ? 8'hFF : PIX_W'(sb.pix_left);
               3: it.data_byte = 8'h00;
               default: it.data_byte = PIX_W'($urandom_range(1, 12));
            endcase
         end else if (r < 3) begin
            it.data_byte = 8'h00;
         end else if (r < 6) begin
            it.data_byte = PIX_W'($urandom_range(1, REMAP_ENTRIES - 1));
         end
      end else if (it.opcode == OP_QUERY) begin
         w  = sb.shp_w;
         h  = sb.shp_h;
         cx = pick_anchor(sb.scr_w);
         cy = pick_anchor(sb.scr_h);
         it.cursor_x = COORD_W'(cx);
         it.cursor_y = COORD_W'(cy);
         if ($urandom_range(0, 4) != 0) begin
            // aim at or just around the shape rectangle
            it.screen_x = COORD_W'(clamp12(cx - int'(sb.hot_x) +
                                           int'($urandom_range(0, w + 3)) - 2));
            it.screen_y = COORD_W'(clamp12(cy - int'(sb.hot_y) +
                                           int'($urandom_range(0, h + 3)) - 2));
         end
         // never read an image entry that no load has written: step just
         // outside the shape instead
         if (sb.locate(it, addr) && !sb.image_valid[addr]) begin
            xs = cx - int'(sb.hot_x);
            it.screen_x = (xs >= 1) ? COORD_W'(xs - 1) : COORD_W'(xs + w);
         end
      end
      return it;
   endfunction

   // Present one item and hold it until an edge with start high and busy low.
   // Start stays high on return so back-to-back items need no second drive.
   task automatic drive_item(input cursor_item_type it);
      start           <= 1'b1;
      req_opcode      <= it.opcode;
      req_table_index <= it.table_index;
      req_data_byte   <= it.data_byte;
      req_cursor_x    <= it.cursor_x;
      req_cursor_y    <= it.cursor_y;
      req_screen_x    <= it.screen_x;
      req_screen_y    <= it.screen_y;
      req_background  <= it.background;
      do @(posedge clock); while (busy !== 1'b0);
      sb.decode_or_overlay(it);
   endtask

   task automatic issue(input cursor_item_type it);
      int n;
      n = pick_gap();
      if (n > 0) begin
         // junk on the request lines while start is low must be ignored
         start         <= 1'b0;
         req_opcode    <= OP_W'($urandom);
         req_data_byte <= PIX_W'($urandom);
         repeat (n) @(posedge clock);
      end
      drive_item(it);
   endtask

   // all results in, then a few quiet cycles
   task automatic drain();
      start <= 1'b0;
      while (sb.overlay_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(value);
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.write_reg(idx, CSR_DATA_W'(value));
   endtask

   task automatic configure(input int sw, input int sh, input int hx, input int hy,
                            input int w, input int h, input int re);
      drain();
      write_csr(CSR_SCREEN_WIDTH, sw);
      write_csr(CSR_SCREEN_HEIGHT, sh);
      write_csr(CSR_HOT_X, hx);
      write_csr(CSR_HOT_Y, hy);
      write_csr(CSR_SHAPE_WIDTH, w);
      write_csr(CSR_SHAPE_HEIGHT, h);
      write_csr(CSR_REMAP_ENABLE, re);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      cursor_item_type it, fill;
      int k;
      reset           = 1'b1;
      start           = 1'b0;
      req_opcode      = OP_START;
      req_table_index = '0;
      req_data_byte   = '0;
      req_cursor_x    = '0;
      req_cursor_y    = '0;
      req_screen_x    = '0;
      req_screen_y    = '0;
      req_background  = '0;
      csr_valid       = 1'b0;
      csr_index       = CSR_SCREEN_WIDTH;
      csr_data        = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // reset defaults: a stream byte with no load running is dropped, and a
      // cursor at the far corner is rejected (all coordinate bits high)
      issue(mk(OP_SHAPE, 0, 'h55, 0, 0, 0, 0, 0));
      issue(mk(OP_QUERY, 15, 'hFF, 4095, 4095, 4095, 4095, 'hFF));

      // 4x3 shape, hotspot (1,1), remap on
      configure(640, 400, 1, 1, 4, 3, 1);
      issue(mk(OP_TABLE, 0, 'h00, 0, 0, 0, 0, 0));
      issue(mk(OP_TABLE, 3, 'h00, 0, 0, 0, 0, 0));    // maps to transparent
      issue(mk(OP_TABLE, 5, 'hA5, 0, 0, 0, 0, 0));
      issue(mk(OP_TABLE, 15, 'hFF, 0, 0, 0, 0, 0));
      issue(mk(OP_START, 0, 0, 0, 0, 0, 0, 0));
      issue(mk(OP_SHAPE, 0, 'h05, 0, 0, 0, 0, 0));    // remapped
      issue(mk(OP_SHAPE, 0, 'h0F, 0, 0, 0, 0, 0));    // highest table entry
      issue(mk(OP_SHAPE, 0, 'h10, 0, 0, 0, 0, 0));    // above table: as is
      issue(mk(OP_SHAPE, 0, 'h03, 0, 0, 0, 0, 0));    // remapped zero
      issue(mk(OP_SHAPE, 0, 'h00, 0, 0, 0, 0, 0));    // run marker
      issue(mk(OP_SHAPE, 0, 'h02, 0, 0, 0, 0, 0));    // run of two
      issue(mk(OP_SHAPE, 0, 'hFF, 0, 0, 0, 0, 0));
      issue(mk(OP_SHAPE, 0, 'h80, 0, 0, 0, 0, 0));
      issue(mk(OP_SHAPE, 0, 'h00, 0, 0, 0, 0, 0));
      issue(mk(OP_SHAPE, 0, 'hC8, 0, 0, 0, 0, 0));    // run too long: clipped
      // shape spans columns 0..3, rows 0..2
      issue(mk(OP_QUERY, 0, 0, 1, 1, 0, 0, 'h11));    // hit
      issue(mk(OP_QUERY, 0, 0, 1, 1, 2, 0, 'h22));    // hit, pass-through byte
      issue(mk(OP_QUERY, 0, 0, 1, 1, 3, 0, 'h33));    // transparent
      issue(mk(OP_QUERY, 0, 0, 1, 1, 3, 1, 'h44));    // hit, last opaque
      issue(mk(OP_QUERY, 0, 0, 1, 1, 4, 0, 'h55));    // right of shape
      issue(mk(OP_QUERY, 0, 0, 640, 1, 639, 0, 'h66)); // one column after clip
      issue(mk(OP_QUERY, 0, 0, 641, 1, 639, 0, 'h77)); // left edge off screen

      // --- random part: phases with fresh register settings ---
      for (k = 0; k < NUM_PHASES; k++) begin
         case (k)
            0: configure(1, 1, 0, 0, 1, 1, 0);
            1: configure(4096, 4096, 63, 63, 64, 64, 1);
            default: configure(pick_screen(), pick_screen(), pick_hot(), pick_hot(),
                               pick_dim(), pick_dim(), $urandom_range(0, 1));
         endcase
         repeat (PHASE_ITEMS) begin
            it = make_item();
            // a remapped pixel must find its table entry written
            if (it.opcode == OP_SHAPE && sb.pix_left != 0 && !sb.run_next &&
                sb.remap_on && it.data_byte != 0 && it.data_byte < REMAP_ENTRIES &&
                !sb.remap_valid[it.data_byte[TBL_W-1:0]]) begin
               fill = it;
               fill.opcode = OP_TABLE;
               fill.table_index = it.data_byte[TBL_W-1:0];
               fill.data_byte = PIX_W'($urandom);
               issue(fill);
            end
            issue(it);
         end
      end

      drain();
      if (sb.mismatches == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

>>> cursor_shape_decode_and_overlay.f
rtl/csdo_pkg.sv
rtl/csdo_ram.sv
rtl/csdo_ctrl.sv
rtl/csdo_dp.sv
rtl/cursor_shape_decode_and_overlay.sv
tb/testbench.sv
